// File: rtl/bphq_pkg.sv
// Shared types, codes and constants of the button press/hold event queue.
// No dependencies; imported by the top level.
package bphq_pkg;

    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_NUM_BUTTONS = 3;

    localparam int TICK_W = 8;
    localparam int WORD_W = 6;
    localparam int DUR_W  = 6;

    localparam logic [TICK_W-1:0] HOLD_TICKS_RESET = 8'd30;
    localparam logic [TICK_W-1:0] COUNT_MAX        = 8'd255;
    localparam logic [DUR_W-1:0]  DUR_PRESS        = 6'd0;
    localparam logic [DUR_W-1:0]  DUR_RELEASE      = 6'd10;
    localparam logic [DUR_W-1:0]  DUR_HOLD         = 6'd60;
    localparam logic [WORD_W-1:0] FLAG_PRESS       = 6'h20;
    localparam logic [WORD_W-1:0] FLAG_HOLD        = 6'h10;

    typedef enum logic [1:0] {
        REQ_EDGE  = 2'd0,
        REQ_TIMER = 2'd1,
        REQ_READ  = 2'd2,
        REQ_CLEAR = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_UP     = 2'd0,
        ST_DOWN   = 2'd1,
        ST_BOUNCE = 2'd2
    } btn_state_t;

    typedef enum logic [1:0] {
        REARM_NONE  = 2'd0,
        REARM_SHORT = 2'd1,
        REARM_LONG  = 2'd2
    } rearm_t;

    typedef enum logic [1:0] {
        IRQ_KEEP    = 2'd0,
        IRQ_DISABLE = 2'd1,
        IRQ_ENABLE  = 2'd2
    } irq_t;

    typedef enum logic [1:0] {
        LEVEL_NONE  = 2'd0,
        LEVEL_CLEAR = 2'd1,
        LEVEL_SET   = 2'd2
    } level_t;

    typedef enum logic [1:0] {
        KIND_RELEASE = 2'd0,
        KIND_PRESS   = 2'd1,
        KIND_HOLD    = 2'd2
    } kind_t;

    localparam logic [1:0] BTN_RESET  = 2'd0;
    localparam logic [1:0] BTN_BACKUP = 2'd1;

    // Key code reported for a button index.
    function automatic logic [1:0] button_key(input logic [1:0] btn);
        logic [1:0] code;
        case (btn)
            2'd0:    code = 2'd1;
            2'd1:    code = 2'd0;
            2'd2:    code = 2'd2;
            default: code = 2'd0;
        endcase
        return code;
    endfunction

endpackage

// File: rtl/bphq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bphq_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/button_press_hold_event_queue.sv
// Top level of the button press/hold event queue.
// Depends on bphq_pkg and bphq_ram.
//
// Usage:
//   s_* channel (valid/ready) carries one request: an edge interrupt, a
//   timer expiry with the sampled pin, a queue read or a queue clear.
//   m_* channel (valid/ready) returns exactly one result per request:
//   timer rearm, interrupt mask and level commands, the event announced
//   (if any), the word popped by a read (if any) and the two sampled
//   button levels.
//   cfg_* channel writes hold_ticks; it is always ready. Write it only
//   while no request is in flight.
// Result: registered; valid in the cycle after request acceptance.
// Throughput: one request per cycle while results are taken; all per-button
//   state and ring pointers update in the cycle of acceptance, and the ring
//   RAM read lands in its output register together with the result register.
// Stall: the result register holds while m_ready is low; s_ready drops
//   only when a result is held and not being taken in the same cycle.
// Reset (aresetn low, synchronous): all buttons up, hold counters and
//   ring pointers zero, levels zero, hold_ticks back to 30, no result
//   pending. Ring entries are not cleared; only written words are read.
module button_press_hold_event_queue
    import bphq_pkg::*;
#(
    parameter  int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter  int NUM_BUTTONS = DEF_NUM_BUTTONS,
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    // configuration write
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [TICK_W-1:0] cfg_hold_ticks,
    // request channel
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_req_type,
    input  logic [1:0]        s_button,
    input  logic              s_pin_level,
    // result channel
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_rearm_timer,
    output logic [1:0]        m_irq_mask_cmd,
    output logic [1:0]        m_level_cmd,
    output logic              m_event_valid,
    output logic [1:0]        m_event_button,
    output logic [1:0]        m_event_kind,
    output logic [DUR_W-1:0]  m_event_duration,
    output logic              m_event_down,
    output logic              m_read_valid,
    output logic [WORD_W-1:0] m_read_code,
    output logic              m_reset_level,
    output logic              m_backup_level
);

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    // ---------------------------------------------------------------
    // State
    // ---------------------------------------------------------------
    logic [TICK_W-1:0] hold_ticks_reg;
    btn_state_t        status_reg [NUM_BUTTONS];
    btn_state_t        status_next [NUM_BUTTONS];
    logic [TICK_W-1:0] count_reg [NUM_BUTTONS];
    logic [TICK_W-1:0] count_next [NUM_BUTTONS];
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic              reset_seen_reg, reset_seen_next;
    logic              backup_seen_reg, backup_seen_next;

    // result register
    logic              m_valid_reg;
    rearm_t            rearm_reg, rearm_next;
    irq_t              irq_reg, irq_next;
    level_t            level_reg, level_next;
    logic              ev_valid_reg, ev_valid_next;
    logic [1:0]        ev_button_reg, ev_button_next;
    kind_t             ev_kind_reg, ev_kind_next;
    logic [DUR_W-1:0]  ev_dur_reg, ev_dur_next;
    logic              ev_down_reg, ev_down_next;
    logic              rd_valid_reg, rd_valid_next;

    // ring RAM port
    logic              ram_we;
    logic [WORD_W-1:0] ram_wdata;
    logic              ram_re;
    logic [WORD_W-1:0] ram_rdata;

    logic              accept;
    req_t              req;
    logic              hit [NUM_BUTTONS];
    logic              btn_ok;
    btn_state_t        sel_status;
    logic [TICK_W-1:0] sel_count;
    btn_state_t        new_status;
    logic [TICK_W-1:0] new_count;
    logic              emit;
    kind_t             emit_kind;
    logic [1:0]        code;

    // Hold a finished result; take a new request whenever it moves on.
    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign req       = req_t'(s_req_type);
    assign code      = button_key(s_button);

    // Decode the addressed button and pick up its state.
    always_comb begin
        btn_ok     = 1'b0;
        sel_status = ST_UP;
        sel_count  = '0;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            hit[i] = (s_button == 2'(i));
            if (hit[i]) begin
                btn_ok     = 1'b1;
                sel_status = status_reg[i];
                sel_count  = count_reg[i];
            end
        end
    end

    // Per-request decision: commands, event and the addressed button's update.
    always_comb begin
        rearm_next       = REARM_NONE;
        irq_next         = IRQ_KEEP;
        level_next       = LEVEL_NONE;
        emit             = 1'b0;
        emit_kind        = KIND_RELEASE;
        rd_valid_next    = 1'b0;
        new_status       = sel_status;
        new_count        = sel_count;
        head_next        = head_reg;
        tail_next        = tail_reg;
        reset_seen_next  = reset_seen_reg;
        backup_seen_next = backup_seen_reg;

        case (req)
            REQ_EDGE: begin
                if (btn_ok) begin
                    // mask all button interrupts and debounce
                    irq_next   = IRQ_DISABLE;
                    rearm_next = REARM_SHORT;
                    new_status = ST_BOUNCE;
                end
            end
            REQ_TIMER: begin
                if (btn_ok) begin
                    if (s_button == BTN_RESET) begin
                        reset_seen_next = s_pin_level;
                    end else if (s_button == BTN_BACKUP) begin
                        backup_seen_next = s_pin_level;
                    end
                    if (s_pin_level) begin
                        if (sel_status == ST_BOUNCE) begin
                            emit       = 1'b1;
                            emit_kind  = KIND_PRESS;
                            new_status = ST_DOWN;
                        end else if (sel_count == hold_ticks_reg) begin
                            // long press: flip polarity, listen for release
                            emit       = 1'b1;
                            emit_kind  = KIND_HOLD;
                            level_next = LEVEL_CLEAR;
                            irq_next   = IRQ_ENABLE;
                        end
                        if (sel_count != COUNT_MAX) begin
                            new_count = sel_count + TICK_W'(1);
                        end
                        rearm_next = REARM_LONG;
                    end else begin
                        if (sel_count > hold_ticks_reg) begin
                            // release after hold: restore polarity only
                            level_next = LEVEL_SET;
                        end else begin
                            emit      = 1'b1;
                            emit_kind = KIND_RELEASE;
                            irq_next  = IRQ_ENABLE;
                        end
                        new_status = ST_UP;
                        new_count  = '0;
                    end
                end
            end
            REQ_READ: begin
                if (head_reg != tail_reg) begin
                    rd_valid_next = 1'b1;
                    tail_next     = (tail_reg == PTR_LAST) ? '0 : tail_reg + PTR_W'(1);
                end
            end
            REQ_CLEAR: begin
                head_next = '0;
                tail_next = '0;
            end
            default: begin
            end
        endcase

        // Write every event, no overflow check.
        if (emit) begin
            head_next = (head_reg == PTR_LAST) ? '0 : head_reg + PTR_W'(1);
        end
    end

    // Event fields and the queued word.
    always_comb begin
        ev_valid_next  = emit;
        ev_button_next = emit ? code : 2'd0;
        ev_kind_next   = emit ? emit_kind : KIND_RELEASE;
        ev_down_next   = emit && (emit_kind == KIND_PRESS);
        ev_dur_next    = '0;
        ram_wdata      = {{(WORD_W-2){1'b0}}, code};
        case (emit_kind)
            KIND_PRESS: begin
                ev_dur_next = DUR_PRESS;
                ram_wdata   = ram_wdata | FLAG_PRESS;
            end
            KIND_HOLD: begin
                ev_dur_next = emit ? DUR_HOLD : '0;
                ram_wdata   = ram_wdata | FLAG_HOLD;
            end
            default: begin
                ev_dur_next = emit ? DUR_RELEASE : '0;
            end
        endcase
    end

    // Apply the update to the addressed button only.
    always_comb begin
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            status_next[i] = status_reg[i];
            count_next[i]  = count_reg[i];
            if (accept && hit[i]) begin
                status_next[i] = new_status;
                count_next[i]  = new_count;
            end
        end
    end

    assign ram_we = accept && emit;
    assign ram_re = accept && rd_valid_next;

    bphq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ring (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (head_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (tail_reg),
        .rdata (ram_rdata)
    );

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_ticks_reg  <= HOLD_TICKS_RESET;
            head_reg        <= '0;
            tail_reg        <= '0;
            reset_seen_reg  <= 1'b0;
            backup_seen_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                status_reg[i] <= ST_UP;
                count_reg[i]  <= '0;
            end
        end else begin
            if (cfg_valid && cfg_ready) begin
                hold_ticks_reg <= cfg_hold_ticks;
            end
            if (accept) begin
                head_reg        <= head_next;
                tail_reg        <= tail_next;
                reset_seen_reg  <= reset_seen_next;
                backup_seen_reg <= backup_seen_next;
                m_valid_reg     <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                status_reg[i] <= status_next[i];
                count_reg[i]  <= count_next[i];
            end
        end
    end

    // Result payload: load on accept, hold otherwise.
    always_ff @(posedge aclk) begin
        if (accept) begin
            rearm_reg     <= rearm_next;
            irq_reg       <= irq_next;
            level_reg     <= level_next;
            ev_valid_reg  <= ev_valid_next;
            ev_button_reg <= ev_button_next;
            ev_kind_reg   <= ev_kind_next;
            ev_dur_reg    <= ev_dur_next;
            ev_down_reg   <= ev_down_next;
            rd_valid_reg  <= rd_valid_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_rearm_timer    = rearm_reg;
    assign m_irq_mask_cmd   = irq_reg;
    assign m_level_cmd      = level_reg;
    assign m_event_valid    = ev_valid_reg;
    assign m_event_button   = ev_button_reg;
    assign m_event_kind     = ev_kind_reg;
    assign m_event_duration = ev_dur_reg;
    assign m_event_down     = ev_down_reg;
    assign m_read_valid     = rd_valid_reg;
    // The RAM output register advances only on a pop, in step with the result.
    assign m_read_code      = rd_valid_reg ? ram_rdata : '0;
    // Levels change only on accept, so they track the held result.
    assign m_reset_level    = reset_seen_reg;
    assign m_backup_level   = backup_seen_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_event_xor_read: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(ev_valid_reg && rd_valid_reg))
        else $error("event and read result in one item");

    a_empty_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && req == REQ_READ && head_reg == tail_reg) |=> !rd_valid_reg)
        else $error("read from empty ring returned an entry");

    a_down_is_press: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && ev_down_reg) |-> (ev_kind_reg == KIND_PRESS
                                          && ev_dur_reg == DUR_PRESS))
        else $error("down action without press event");

    a_edge_masks: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && req == REQ_EDGE && btn_ok) |=> (irq_reg == IRQ_DISABLE
                                                   && !ev_valid_reg))
        else $error("edge request did not mask interrupts");

endmodule

// File: tb/sv/bphq_event_checker.sv
// Result checker for the button press/hold event queue: watches the request,
// configuration and result channels, predicts each result and compares it.
// Depends on bphq_pkg.
module bphq_event_checker
    import bphq_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [TICK_W-1:0] cfg_hold_ticks,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic [1:0]        s_req_type,
    input  logic [1:0]        s_button,
    input  logic              s_pin_level,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic [1:0]        m_rearm_timer,
    input  logic [1:0]        m_irq_mask_cmd,
    input  logic [1:0]        m_level_cmd,
    input  logic              m_event_valid,
    input  logic [1:0]        m_event_button,
    input  logic [1:0]        m_event_kind,
    input  logic [DUR_W-1:0]  m_event_duration,
    input  logic              m_event_down,
    input  logic              m_read_valid,
    input  logic [WORD_W-1:0] m_read_code,
    input  logic              m_reset_level,
    input  logic              m_backup_level,
    output int                fail_count,
    output int                in_flight
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_DEPTH = DEF_QUEUE_DEPTH;
    localparam int PTR_W      = $clog2(RING_DEPTH);

    localparam logic [1:0] KEY_RESET  = 2'd1;
    localparam logic [1:0] KEY_BACKUP = 2'd0;
    localparam logic [1:0] KEY_POWER  = 2'd2;

    typedef struct packed {
        rearm_t             rearm;
        irq_t               irq;
        level_t             level;
        logic               ev_valid;
        logic [1:0]         ev_button;
        kind_t              ev_kind;
        logic [DUR_W-1:0]   ev_dur;
        logic               ev_down;
        logic               rd_valid;
        logic [WORD_W-1:0]  rd_code;
        logic               rst_lvl;
        logic               bkp_lvl;
    } button_result_t;

    button_result_t    expected_q[$];
    button_result_t    want;
    btn_state_t        status   [DEF_NUM_BUTTONS];
    logic [TICK_W-1:0] hold_cnt [DEF_NUM_BUTTONS];
    logic [WORD_W-1:0] ring     [RING_DEPTH];
    logic [PTR_W-1:0]  head;
    logic [PTR_W-1:0]  tail;
    logic [TICK_W-1:0] hold_ticks;
    logic              rst_seen;
    logic              bkp_seen;
    logic [1:0]        btn;
    logic              pin;
    int                fail_total = 0;

    // Queue one event word and announce it in the result.
    task automatic log_event(input logic [1:0] b, input kind_t kind,
                             inout button_result_t r);
        logic [1:0]        code;
        logic [WORD_W-1:0] word;
        case (b)
            BTN_RESET:  code = KEY_RESET;
            BTN_BACKUP: code = KEY_BACKUP;
            default:    code = KEY_POWER;
        endcase
        word = {{(WORD_W-2){1'b0}}, code};
        if (kind == KIND_PRESS)
            word = word | FLAG_PRESS;
        else if (kind == KIND_HOLD)
            word = word | FLAG_HOLD;
        ring[head] = word;
        head = (int'(head) == RING_DEPTH - 1) ? '0 : head + PTR_W'(1);
        r.ev_valid  = 1'b1;
        r.ev_button = code;
        r.ev_kind   = kind;
        r.ev_dur    = (kind == KIND_HOLD) ? DUR_HOLD :
                      (kind == KIND_PRESS) ? DUR_PRESS : DUR_RELEASE;
        r.ev_down   = (kind == KIND_PRESS);
    endtask

    task automatic compare_field(input string name, input logic [7:0] want_v,
                                 input logic [7:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            fail_total++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn !== 1'b1) begin
            for (int i = 0; i < DEF_NUM_BUTTONS; i++) begin
                status[i]   = ST_UP;
                hold_cnt[i] = '0;
            end
            head       = '0;
            tail       = '0;
            rst_seen   = 1'b0;
            bkp_seen   = 1'b0;
            hold_ticks = HOLD_TICKS_RESET;
            expected_q.delete();
        end else begin
            // Results first: a result taken at this edge belongs to an older request.
            if (m_valid === 1'b1 && m_ready === 1'b1) begin
                if (expected_q.size() == 0) begin
                    $error("result with no request outstanding");
                    fail_total++;
                end else begin
                    want = expected_q.pop_front();
                    compare_field("rearm_timer", 8'(want.rearm), 8'(m_rearm_timer));
                    compare_field("irq_mask_cmd", 8'(want.irq), 8'(m_irq_mask_cmd));
                    compare_field("level_cmd", 8'(want.level), 8'(m_level_cmd));
                    compare_field("event_valid", 8'(want.ev_valid), 8'(m_event_valid));
                    compare_field("event_button", 8'(want.ev_button),
                                  8'(m_event_button));
                    compare_field("event_kind", 8'(want.ev_kind), 8'(m_event_kind));
                    compare_field("event_duration", 8'(want.ev_dur),
                                  8'(m_event_duration));
                    compare_field("event_down", 8'(want.ev_down), 8'(m_event_down));
                    compare_field("read_valid", 8'(want.rd_valid), 8'(m_read_valid));
                    compare_field("read_code", 8'(want.rd_code), 8'(m_read_code));
                    compare_field("reset_level", 8'(want.rst_lvl), 8'(m_reset_level));
                    compare_field("backup_level", 8'(want.bkp_lvl),
                                  8'(m_backup_level));
                end
            end

            if (cfg_valid === 1'b1 && cfg_ready === 1'b1)
                hold_ticks = cfg_hold_ticks;

            if (s_valid === 1'b1 && s_ready === 1'b1) begin
                want = '0;
                btn  = s_button;
                pin  = s_pin_level;
                case (req_t'(s_req_type))
                    REQ_EDGE: begin
                        if (btn < DEF_NUM_BUTTONS) begin
                            want.irq    = IRQ_DISABLE;
                            want.rearm  = REARM_SHORT;
                            status[btn] = ST_BOUNCE;
                        end
                    end
                    REQ_TIMER: begin
                        if (btn < DEF_NUM_BUTTONS) begin
                            if (btn == BTN_RESET)
                                rst_seen = pin;
                            else if (btn == BTN_BACKUP)
                                bkp_seen = pin;
                            if (pin) begin
                                if (status[btn] == ST_BOUNCE) begin
                                    log_event(btn, KIND_PRESS, want);
                                    status[btn] = ST_DOWN;
                                end else if (hold_cnt[btn] == hold_ticks) begin
                                    log_event(btn, KIND_HOLD, want);
                                    want.level = LEVEL_CLEAR;
                                    want.irq   = IRQ_ENABLE;
                                end
                                if (hold_cnt[btn] != COUNT_MAX)
                                    hold_cnt[btn] = hold_cnt[btn] + TICK_W'(1);
                                want.rearm = REARM_LONG;
                            end else begin
                                // After a hold only the polarity is restored.
                                if (hold_cnt[btn] > hold_ticks) begin
                                    want.level = LEVEL_SET;
                                end else begin
                                    log_event(btn, KIND_RELEASE, want);
                                    want.irq = IRQ_ENABLE;
                                end
                                status[btn]   = ST_UP;
                                hold_cnt[btn] = '0;
                            end
                        end
                    end
                    REQ_READ: begin
                        if (head != tail) begin
                            want.rd_valid = 1'b1;
                            want.rd_code  = ring[tail];
                            tail = (int'(tail) == RING_DEPTH - 1) ? '0 : tail + PTR_W'(1);
                        end
                    end
                    default: begin
                        head = '0;
                        tail = '0;
                    end
                endcase
                want.rst_lvl = rst_seen;
                want.bkp_lvl = bkp_seen;
                expected_q.push_back(want);
            end
        end
        in_flight  <= expected_q.size();
        fail_count <= fail_total;
    end

endmodule

// File: tb/sv/tb.sv
// Testbench top for the button press/hold event queue: clock, reset, request
// and configuration stimulus, result-side back-pressure and the verdict.
// Depends on bphq_pkg, button_press_hold_event_queue and bphq_event_checker.
module tb
    import bphq_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASE_ITEMS = 8;
    localparam int NUM_PHASES  = 7;
    localparam int HOLDOFF_LEN = 64;

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [TICK_W-1:0] cfg_hold_ticks;
    logic              s_valid;
    logic              s_ready;
    logic [1:0]        s_req_type;
    logic [1:0]        s_button;
    logic              s_pin_level;
    logic              m_valid;
    logic              m_ready;
    logic [1:0]        m_rearm_timer;
    logic [1:0]        m_irq_mask_cmd;
    logic [1:0]        m_level_cmd;
    logic              m_event_valid;
    logic [1:0]        m_event_button;
    logic [1:0]        m_event_kind;
    logic [DUR_W-1:0]  m_event_duration;
    logic              m_event_down;
    logic              m_read_valid;
    logic [WORD_W-1:0] m_read_code;
    logic              m_reset_level;
    logic              m_backup_level;

    int                fail_count;
    int                in_flight;

    // Stimulus knobs; steady, holdoff_req and holdoff_done are shared with the result-side process.
    logic              steady;        // no idling on either side while set
    logic              holdoff_req;   // ask the receiver for one long stall
    logic              holdoff_done;
    int                sent;
    logic [TICK_W-1:0] hold_now;

    always #5 aclk = ~aclk;

    button_press_hold_event_queue u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_hold_ticks   (cfg_hold_ticks),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_req_type       (s_req_type),
        .s_button         (s_button),
        .s_pin_level      (s_pin_level),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_rearm_timer    (m_rearm_timer),
        .m_irq_mask_cmd   (m_irq_mask_cmd),
        .m_level_cmd      (m_level_cmd),
        .m_event_valid    (m_event_valid),
        .m_event_button   (m_event_button),
        .m_event_kind     (m_event_kind),
        .m_event_duration (m_event_duration),
        .m_event_down     (m_event_down),
        .m_read_valid     (m_read_valid),
        .m_read_code      (m_read_code),
        .m_reset_level    (m_reset_level),
        .m_backup_level   (m_backup_level)
    );

    bphq_event_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_hold_ticks   (cfg_hold_ticks),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_req_type       (s_req_type),
        .s_button         (s_button),
        .s_pin_level      (s_pin_level),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_rearm_timer    (m_rearm_timer),
        .m_irq_mask_cmd   (m_irq_mask_cmd),
        .m_level_cmd      (m_level_cmd),
        .m_event_valid    (m_event_valid),
        .m_event_button   (m_event_button),
        .m_event_kind     (m_event_kind),
        .m_event_duration (m_event_duration),
        .m_event_down     (m_event_down),
        .m_read_valid     (m_read_valid),
        .m_read_code      (m_read_code),
        .m_reset_level    (m_reset_level),
        .m_backup_level   (m_backup_level),
        .fail_count       (fail_count),
        .in_flight        (in_flight)
    );

    // Offer one request and hold it until the block takes it. Idle first now
    // and then, unless the steady stretch is on.
    task automatic issue(input req_t req, input logic [1:0] btn, input logic pin);
        if (!steady && $urandom_range(0, 99) < 9) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_req_type  <= req;
        s_button    <= btn;
        s_pin_level <= pin;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent++;
    endtask

    // Drop valid and wait until every outstanding request has its result.
    // in_flight is registered, so skip the edge of the last acceptance.
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (in_flight != 0) @(posedge aclk);
    endtask

    // Write hold_ticks with the block idle.
    task automatic write_hold_ticks(input logic [TICK_W-1:0] value);
        settle();
        cfg_valid      <= 1'b1;
        cfg_hold_ticks <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        hold_now = value;
    endtask

    // One well-formed press: edge, debounce tick, long ticks, release tick.
    // Sprinkle queue reads between the ticks.
    task automatic press_cycle(input logic [1:0] btn, input int ticks, input int read_pct);
        issue(REQ_EDGE, btn, 1'($urandom_range(0, 1)));
        repeat (ticks) begin
            issue(REQ_TIMER, btn, 1'b1);
            if ($urandom_range(0, 99) < read_pct)
                issue(REQ_READ, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
        end
        issue(REQ_TIMER, btn, 1'b0);
    endtask

    // Noise: any request type, any button index, any pin; clears stay rare
    // so the ring gets a chance to fill.
    task automatic stray();
        int   pick;
        logic [1:0] btn;
        logic pin;
        pick = $urandom_range(0, 99);
        btn  = 2'($urandom_range(0, 3));
        pin  = 1'($urandom_range(0, 1));
        if (pick < 40)
            issue(REQ_READ, btn, pin);
        else if (pick < 60)
            issue(REQ_EDGE, btn, pin);
        else if (pick < 93)
            issue(REQ_TIMER, btn, pin);
        else
            issue(REQ_CLEAR, btn, pin);
    endtask

    // Result side: random back-pressure, one long hold-off on request.
    initial begin
        m_ready      = 1'b0;
        holdoff_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (holdoff_req && !holdoff_done) begin
                m_ready <= 1'b0;
                for (int held = 0; held < HOLDOFF_LEN; held++) @(posedge aclk);
                holdoff_done = 1'b1;
            end
            m_ready <= steady || ($urandom_range(0, 99) >= 9);
        end
    end

    initial begin
        logic [TICK_W-1:0] plan [NUM_PHASES];
        int                mark;
        logic [1:0]        btn;
        int                ticks;

        aresetn        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_hold_ticks = '0;
        s_valid        = 1'b0;
        s_req_type     = REQ_EDGE;
        s_button       = '0;
        s_pin_level    = 1'b0;
        steady         = 1'b0;
        holdoff_req    = 1'b0;
        sent           = 0;
        hold_now       = HOLD_TICKS_RESET;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty read, clear, a press and release on every button,
        // an out-of-range button, a timer while up, three reads, then clear the ring.
        issue(REQ_READ, 2'd3, 1'b1);
        issue(REQ_CLEAR, 2'd3, 1'b0);
        press_cycle(BTN_RESET, 1, 0);
        press_cycle(BTN_BACKUP, 1, 0);
        press_cycle(2'd2, 1, 0);
        issue(REQ_EDGE, 2'd3, 1'b0);
        issue(REQ_TIMER, 2'd3, 1'b1);
        issue(REQ_TIMER, 2'd2, 1'b1);
        issue(REQ_TIMER, 2'd2, 1'b0);
        repeat (3) issue(REQ_READ, 2'd0, 1'b0);
        issue(REQ_CLEAR, 2'd0, 1'b1);
        issue(REQ_READ, 2'd1, 1'b0);
        // Shortest hold: press, hold with polarity flip, silent tick, quiet release.
        write_hold_ticks(8'd1);
        press_cycle(BTN_RESET, 3, 0);

        // Random phases over several hold_ticks settings, extremes included.
        plan[0] = 8'd0;
        plan[1] = 8'd255;
        plan[2] = 8'd2;
        plan[3] = 8'd254;
        plan[4] = 8'($urandom_range(3, 12));
        plan[5] = HOLD_TICKS_RESET;
        plan[6] = 8'd1;

        for (int p = 0; p < NUM_PHASES; p++) begin
            // Settle before the write: the sender pauses until all results are in.
            write_hold_ticks(plan[p]);
            steady      <= (p == 1);
            holdoff_req <= (p >= 3);

            // Saturate the counter and see the hold repeat at 255.
            if (plan[p] == 8'd255)
                press_cycle(2'd2, 258, 0);

            // Overflow the ring: many events with no reads, then drain it.
            if (p == 5) begin
                repeat (10) press_cycle(2'($urandom_range(0, 2)), 1, 0);
                repeat (22) issue(REQ_READ, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
            end

            mark = sent;
            while (sent - mark < PHASE_ITEMS) begin
                if ($urandom_range(0, 99) < 70) begin
                    btn = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
                    if (hold_now <= 8'd40)
                        ticks = $urandom_range(0, int'(hold_now) + 3);
                    else
                        ticks = $urandom_range(0, 6);
                    press_cycle(btn, ticks, 15);
                end else begin
                    repeat ($urandom_range(1, 3)) stray();
                end
            end
        end

        settle();
        repeat (4) @(posedge aclk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Hang guard.
    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// File: filelist.f
rtl/bphq_pkg.sv
rtl/bphq_ram.sv
rtl/button_press_hold_event_queue.sv
tb/sv/bphq_event_checker.sv
tb/sv/tb.sv
